[sv/code_zone_cycle_profiler_macros.svh]
// Assertion macros used by the profiler top level.
`ifndef CODE_ZONE_CYCLE_PROFILER_MACROS_SVH
`define CODE_ZONE_CYCLE_PROFILER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CZP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication with the consequent checked in the cycle after the antecedent.
`define CZP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[sv/czp_pkg.sv]
// Shared types and constants of the code zone cycle profiler.
`default_nettype none
package czp_pkg;
    localparam logic [2:0] OP_BEGIN = 3'd0;
    localparam logic [2:0] OP_END   = 3'd1;
    localparam logic [2:0] OP_READ  = 3'd2;
    localparam logic [2:0] OP_STATS = 3'd3;
    localparam logic [2:0] OP_CLEAR = 3'd4;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    // Per-zone record held by one cell.
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] start;
        logic [31:0] count;
        logic [31:0] total;
        logic [31:0] min;
        logic [31:0] max;
        logic [31:0] avg;
        logic        active;
    } t_zone;

    // Command broadcast from the controller to the cells.
    typedef struct packed {
        logic        shift;   // rotate the whole chain by one cell
        logic        load;    // replace the head record
    } t_chain_ctl;
endpackage
`default_nettype wire

[sv/czp_cell.sv]
// One storage cell of the zone chain; takes the record of the cell after it in the ring on shift.
`default_nettype none
module czp_cell (
    input  wire logic                i_clk,
    input  wire czp_pkg::t_chain_ctl i_ctl,
    input  wire czp_pkg::t_zone      i_prev,
    input  wire logic                i_head,
    input  wire czp_pkg::t_zone      i_load,
    output czp_pkg::t_zone           o_zone
);
    czp_pkg::t_zone r_zone;
    czp_pkg::t_zone n_zone;

    always_comb begin
        n_zone = r_zone;
        if (i_ctl.shift) begin
            n_zone = i_prev;
        end else if (i_ctl.load && i_head) begin
            n_zone = i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zone <= n_zone;
    end

    assign o_zone = r_zone;
endmodule
`default_nettype wire

[sv/czp_divider.sv]
// Radix-2 restoring divider for the per-zone average, one quotient bit a cycle.
`default_nettype none
module czp_divider (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_num,
    input  wire logic [31:0] i_den,
    output logic             o_done,
    output logic [31:0]      o_quot
);
    logic [31:0] r_quot, n_quot;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_den, n_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [32:0] w_try;

    always_comb begin
        n_quot = r_quot;
        n_rem  = r_rem;
        n_den  = r_den;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        w_try  = {r_rem[31:0], r_quot[31]};
        if (i_start) begin
            n_quot = i_num;
            n_rem  = '0;
            n_den  = i_den;
            n_cnt  = 6'd32;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_try >= {1'b0, r_den}) begin
                n_rem  = w_try - {1'b0, r_den};
                n_quot = {r_quot[30:0], 1'b1};
            end else begin
                n_rem  = w_try;
                n_quot = {r_quot[30:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_den  <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
`default_nettype wire

[sv/code_zone_cycle_profiler.sv]
// Top level of the code zone cycle profiler: controller, zone chain and divider.
//
//  Channel | Direction | Handshake            | Payload
//  s_axis  | in        | tvalid/tready        | tdata: operation, key, index, stamp
//  m_axis  | out       | tvalid/tready        | tdata: status and statistics
//  cfg     | in        | i_cfg_we (no wait)   | i_cfg_wdata: enabled
//
// The zones live in a ring of cells that rotates by one cell per cycle while
// the controller shifts it; the controller only ever looks at the head cell.
// Each operation rotates the ring until the wanted slot sits at the head, works
// on it there, then rotates on in the same direction until slot 0 is back at
// the head. An accepted end also waits there for the bit-serial divider.
// One item is worked on at a time; tready is high only while idle and no beat
// waits in the output register, so a new beat is taken only once the last
// result has left that register. Reset is synchronous, active low, and clears
// only control state and global counters; cells need no reset since slots
// beyond the used count are never read. A stalled output holds the block.
`default_nettype none
`include "code_zone_cycle_profiler_macros.svh"
module code_zone_cycle_profiler #(
    parameter int ZONE_SLOTS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_wdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // tdata from bit 0: operation[2:0], zone_key[34:3], zone_index[38:35],
    // cycle_stamp[70:39], zero fill to 72 bits.
    input  wire logic [71:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // tdata from bit 0: status[0], result_index[4:1], calls[36:5],
    // cycle_sum[68:37], shortest[100:69], longest[132:101],
    // mean[164:133], zone_active[165], zones_in_use[170:166],
    // sample_count[202:171], refusals[234:203], active_count[239:235].
    output logic [239:0]      m_axis_tdata
);
    localparam int CW = $clog2(ZONE_SLOTS + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SCAN = 6'b000010,
        S_WORK = 6'b000100,
        S_DIV  = 6'b001000,
        S_BACK = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic r_en;
    logic [2:0]  r_op;
    logic [31:0] r_key, r_stamp;
    logic [3:0]  r_idx;
    logic [CW-1:0] r_pos, n_pos;       // slot number at the head
    logic [CW-1:0] r_used, n_used, r_act, n_act;
    logic [31:0] r_samp, n_samp, r_ref, n_ref;
    logic        r_found, n_found;
    logic [239:0] r_out, n_out;
    logic        r_ovld, n_ovld;
    logic        r_rej, n_rej;
    czp_pkg::t_zone w_load;
    czp_pkg::t_chain_ctl w_ctl;
    czp_pkg::t_zone w_zone [ZONE_SLOTS];
    czp_pkg::t_zone w_head;
    logic        w_div_start, w_div_done;
    logic [31:0] w_quot, w_el, w_tot, w_cnt;

    genvar g;
    generate
        for (g = 0; g < ZONE_SLOTS; g++) begin : g_cell
            czp_cell u_cell (
                .i_clk  (i_clk),
                .i_ctl  (w_ctl),
                .i_prev (w_zone[(g + 1) % ZONE_SLOTS]),
                .i_head (g == 0),
                .i_load (w_load),
                .o_zone (w_zone[g])
            );
        end
    endgenerate
    assign w_head = w_zone[0];

    // End arithmetic from the head record, taken while it sits still.
    assign w_el  = r_stamp - w_head.start;
    assign w_cnt = (w_head.count == czp_pkg::ALL_ONES) ? w_head.count : w_head.count + 32'd1;
    assign w_tot = w_head.total + w_el;

    czp_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_tot),
        .i_den   (w_cnt),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    logic w_at_end;
    logic w_idx_ok;
    assign w_at_end = (r_pos == CW'(ZONE_SLOTS - 1));
    // The full index is compared so that no slot count truncates it.
    assign w_idx_ok = (32'(r_idx) < 32'(r_used));

    always_comb begin
        n_state = r_state;
        n_pos = r_pos;
        n_used = r_used; n_act = r_act; n_samp = r_samp; n_ref = r_ref;
        n_found = r_found;
        n_out = r_out; n_ovld = r_ovld; n_rej = r_rej;
        w_ctl = '0;
        w_load = w_head;
        w_div_start = 1'b0;
        if (r_ovld && m_axis_tready) n_ovld = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid && !r_ovld) begin
                    n_state = S_SCAN;
                    n_found = 1'b0;
                    n_pos = '0;
                end
            end
            S_SCAN: begin
                // Stop when the head holds the slot this operation needs.
                priority if (!r_en || r_op > czp_pkg::OP_CLEAR
                             || r_op == czp_pkg::OP_STATS || r_op == czp_pkg::OP_CLEAR) begin
                    n_state = S_WORK;
                end else if (r_op == czp_pkg::OP_BEGIN) begin
                    if (r_key == '0 || r_pos >= r_used) begin
                        n_state = S_WORK;
                    end else if (w_head.key == r_key) begin
                        n_found = 1'b1;
                        n_state = S_WORK;
                    end else begin
                        w_ctl.shift = 1'b1;
                        n_pos = r_pos + CW'(1);
                    end
                end else begin
                    if (!w_idx_ok || CW'(r_idx) == r_pos) begin
                        n_state = S_WORK;
                    end else begin
                        w_ctl.shift = 1'b1;
                        n_pos = r_pos + CW'(1);
                    end
                end
            end
            S_WORK: begin
                n_out = '0;
                n_rej = 1'b1;
                n_state = S_BACK;
                if (r_en) begin
                    unique case (r_op)
                        czp_pkg::OP_BEGIN: begin
                            if (r_key != '0) begin
                                if (!r_found && r_used >= CW'(ZONE_SLOTS)) begin
                                    n_ref = r_ref + 32'd1;
                                end else begin
                                    n_rej = 1'b0;
                                    if (!r_found) begin
                                        w_load.key = r_key;
                                        w_load.count = '0;
                                        w_load.total = '0;
                                        w_load.min = czp_pkg::ALL_ONES;
                                        w_load.max = '0;
                                        w_load.avg = '0;
                                        w_load.active = 1'b0;
                                        n_used = r_used + CW'(1);
                                    end
                                    w_load.start = r_stamp;
                                    if (r_found ? !w_head.active : 1'b1) begin
                                        w_load.active = 1'b1;
                                        n_act = r_act + CW'(1);
                                    end
                                    w_ctl.load = 1'b1;
                                    n_out[4:1] = 4'(r_pos);
                                end
                            end
                        end
                        czp_pkg::OP_END: begin
                            if (w_idx_ok && w_head.active) begin
                                n_rej = 1'b0;
                                w_div_start = 1'b1;
                                n_state = S_DIV;
                            end
                        end
                        czp_pkg::OP_READ: begin
                            if (w_idx_ok) begin
                                n_rej = 1'b0;
                                n_out[36:5] = w_head.count;
                                n_out[68:37] = w_head.total;
                                n_out[100:69] = w_head.min;
                                n_out[132:101] = w_head.max;
                                n_out[164:133] = w_head.avg;
                                n_out[165] = w_head.active;
                            end
                        end
                        czp_pkg::OP_STATS: begin
                            n_rej = 1'b0;
                            n_out[170:166] = 5'(r_used);
                            n_out[202:171] = r_samp;
                            n_out[234:203] = r_ref;
                            n_out[239:235] = 5'(r_act);
                        end
                        czp_pkg::OP_CLEAR: begin
                            n_rej = 1'b0;
                            n_used = '0; n_act = '0; n_samp = '0; n_ref = '0;
                        end
                        default: n_rej = 1'b1;
                    endcase
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    w_load.count = w_cnt;
                    w_load.total = w_tot;
                    if (w_el < w_head.min) w_load.min = w_el;
                    if (w_el > w_head.max) w_load.max = w_el;
                    w_load.avg = w_quot;
                    w_load.active = 1'b0;
                    w_ctl.load = 1'b1;
                    if (r_act != '0) n_act = r_act - CW'(1);
                    n_samp = r_samp + 32'd1;
                    n_state = S_BACK;
                end
            end
            S_BACK: begin
                // Rotate on until slot 0 is back at the head. A begin that scanned a full
                // table without a hit has already gone once around the ring.
                if (r_pos == '0 || r_pos == CW'(ZONE_SLOTS)) begin
                    n_state = S_OUT;
                end else begin
                    w_ctl.shift = 1'b1;
                    n_pos = w_at_end ? '0 : r_pos + CW'(1);
                end
            end
            S_OUT: begin
                if (!r_ovld) begin
                    n_out[0] = r_rej;
                    if (r_rej) n_out = 240'd1;
                    n_ovld = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_en <= 1'b0;
            r_pos <= '0;
            r_used <= '0; r_act <= '0; r_samp <= '0; r_ref <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_en <= i_cfg_wdata;
            r_pos <= n_pos;
            r_used <= n_used; r_act <= n_act; r_samp <= n_samp; r_ref <= n_ref;
            r_ovld <= n_ovld;
        end
        r_found <= n_found;
        r_out <= n_out;
        r_rej <= n_rej;
        if (s_axis_tvalid && s_axis_tready) begin
            r_op <= s_axis_tdata[2:0];
            r_key <= s_axis_tdata[34:3];
            r_idx <= s_axis_tdata[38:35];
            r_stamp <= s_axis_tdata[70:39];
        end
    end

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovld;
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata = r_out;

    `CZP_ASSERT_IMPL(a_used_max, i_clk, i_rst_n, 1'b1, r_used <= CW'(ZONE_SLOTS), "used count too large")
    `CZP_ASSERT_IMPL(a_act_le_used, i_clk, i_rst_n, 1'b1, r_act <= r_used, "active above used")
    `CZP_ASSERT_NEXT(a_idle_home, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, r_state == S_SCAN && r_pos == '0, "chain not home on accept")
endmodule
`default_nettype wire

[tb/tb_profiler_checker.sv]
// Result predictor and checker for the code zone cycle profiler testbench.
`default_nettype none
module tb_profiler_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic         i_cfg_wdata,
    input  wire logic         i_in_valid,
    input  wire logic         i_in_ready,
    input  wire logic [71:0]  i_in_data,
    input  wire logic         i_out_valid,
    input  wire logic         i_out_ready,
    input  wire logic [239:0] i_out_data,
    output int                o_fail_count,
    output int                o_pending
);
    typedef struct packed {
        logic        status;
        logic [3:0]  slot;
        logic [31:0] calls;
        logic [31:0] total;
        logic [31:0] min_c;
        logic [31:0] max_c;
        logic [31:0] avg_c;
        logic        active;
        logic [4:0]  used;
        logic [31:0] samples;
        logic [31:0] refused;
        logic [4:0]  live;
    } t_answer;

    logic        prof_on;
    logic [31:0] keys [16];
    logic [31:0] starts [16];
    logic [31:0] calls [16];
    logic [31:0] totals [16];
    logic [31:0] mins [16];
    logic [31:0] maxs [16];
    logic [31:0] avgs [16];
    logic        live_flag [16];
    logic [4:0]  used_n;
    logic [31:0] sample_n;
    logic [31:0] refused_n;
    logic [4:0]  live_n;
    t_answer     answers_due [$];
    int          beat_no;

    assign o_pending = answers_due.size();

    function automatic t_answer unpack_answer(logic [239:0] d);
        t_answer a;
        a.status = d[0];       a.slot = d[4:1];       a.calls = d[36:5];
        a.total = d[68:37];    a.min_c = d[100:69];   a.max_c = d[132:101];
        a.avg_c = d[164:133];  a.active = d[165];     a.used = d[170:166];
        a.samples = d[202:171]; a.refused = d[234:203]; a.live = d[239:235];
        return a;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("beat %0d: %s got %h expected %h", beat_no, what, got, want);
        o_fail_count++;
    endtask

    task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got != want) report_mismatch(what, got, want);
    endtask

    // Applies one command to the shadow table and returns the answer it gives.
    function automatic t_answer profile_step(logic [71:0] d);
        t_answer     a;
        logic [2:0]  op;
        logic [31:0] key, stamp, elapsed;
        logic [3:0]  idx;
        int          hit;
        logic        ok;
        op = d[2:0]; key = d[34:3]; idx = d[38:35]; stamp = d[70:39];
        a = '0;
        ok = 1'b0;
        if (prof_on) begin
            case (op)
                czp_pkg::OP_BEGIN: if (key != '0) begin
                    hit = -1;
                    for (int i = 0; i < int'(used_n); i++)
                        if (hit < 0 && keys[i] == key) hit = i;
                    if (hit < 0 && used_n >= 5'd16) begin
                        refused_n++;
                    end else begin
                        if (hit < 0) begin
                            hit = int'(used_n);
                            used_n++;
                            keys[hit] = key; calls[hit] = '0; totals[hit] = '0;
                            mins[hit] = czp_pkg::ALL_ONES; maxs[hit] = '0; avgs[hit] = '0;
                            live_flag[hit] = 1'b0;
                        end
                        starts[hit] = stamp;
                        if (!live_flag[hit]) begin
                            live_flag[hit] = 1'b1;
                            live_n++;
                        end
                        a.slot = hit[3:0];
                        ok = 1'b1;
                    end
                end
                czp_pkg::OP_END: if (5'(idx) < used_n && live_flag[idx]) begin
                    elapsed = stamp - starts[idx];
                    if (calls[idx] != czp_pkg::ALL_ONES) calls[idx]++;
                    totals[idx] += elapsed;
                    if (elapsed < mins[idx]) mins[idx] = elapsed;
                    if (elapsed > maxs[idx]) maxs[idx] = elapsed;
                    avgs[idx] = totals[idx] / calls[idx];
                    live_flag[idx] = 1'b0;
                    if (live_n > 5'd0) live_n--;
                    sample_n++;
                    ok = 1'b1;
                end
                czp_pkg::OP_READ: if (5'(idx) < used_n) begin
                    a.calls = calls[idx]; a.total = totals[idx]; a.min_c = mins[idx];
                    a.max_c = maxs[idx]; a.avg_c = avgs[idx]; a.active = live_flag[idx];
                    ok = 1'b1;
                end
                czp_pkg::OP_STATS: begin
                    a.used = used_n; a.samples = sample_n;
                    a.refused = refused_n; a.live = live_n;
                    ok = 1'b1;
                end
                czp_pkg::OP_CLEAR: begin
                    used_n = '0; sample_n = '0; refused_n = '0; live_n = '0;
                    ok = 1'b1;
                end
                default: ok = 1'b0;
            endcase
        end
        if (!ok) a = '0;
        a.status = !ok;
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer got, want;
        if (!i_rst_n) begin
            prof_on <= 1'b0;
            used_n = '0; sample_n = '0; refused_n = '0; live_n = '0;
            answers_due.delete();
            o_fail_count = 0;
            beat_no = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                got = unpack_answer(i_out_data);
                if (answers_due.size() == 0) begin
                    report_mismatch("unexpected beat", 32'd0, 32'd0);
                end else begin
                    want = answers_due.pop_front();
                    check_field("status", 32'(got.status), 32'(want.status));
                    check_field("result_index", 32'(got.slot), 32'(want.slot));
                    check_field("calls", got.calls, want.calls);
                    check_field("cycle sum", got.total, want.total);
                    check_field("shortest", got.min_c, want.min_c);
                    check_field("longest", got.max_c, want.max_c);
                    check_field("mean", got.avg_c, want.avg_c);
                    check_field("zone_active", 32'(got.active), 32'(want.active));
                    check_field("zones_in_use", 32'(got.used), 32'(want.used));
                    check_field("sample_count", got.samples, want.samples);
                    check_field("refusals", got.refused, want.refused);
                    check_field("active_count", 32'(got.live), 32'(want.live));
                end
                beat_no++;
            end
            if (i_in_valid && i_in_ready) answers_due.push_back(profile_step(i_in_data));
            if (i_cfg_we) prof_on <= i_cfg_wdata;
        end
    end
endmodule
`default_nettype wire

[tb/tb_top.sv]
// Top of the code zone cycle profiler testbench: stimulus, idling and verdict.
`default_nettype none
module tb_top;
    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic         cfg_wdata;
    logic         in_valid;
    logic         in_ready;
    logic [71:0]  in_data;   // operation, zone_key, zone_index, cycle_stamp, zero fill
    logic         out_valid;
    logic         out_ready;
    logic [239:0] out_data;  // status, result_index, zone and global statistics
    int           fail_count;
    int           pending;

    // Percent chance per cycle that the sender idles and the receiver stalls.
    int           send_idle_pct;
    int           recv_stall_pct;
    // When set, the receiver process holds tready low for a long stretch.
    logic         hold_off_req;
    int           items_sent;
    // Keys that the random part reuses so that begins hit existing zones.
    logic [31:0]  key_pool [24];
    logic [31:0]  stamp_now;

    code_zone_cycle_profiler #(.ZONE_SLOTS(16)) u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .s_axis_tvalid(in_valid), .s_axis_tready(in_ready), .s_axis_tdata(in_data),
        .m_axis_tvalid(out_valid), .m_axis_tready(out_ready), .m_axis_tdata(out_data)
    );

    tb_profiler_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // The receiver stalls at the configured rate; a hold-off request forces a long
    // stall so that the block fills and drops its input ready.
    initial begin
        out_ready = 0;
        forever begin
            @(posedge clk);
            if (hold_off_req) begin
                out_ready <= 0;
                repeat (400) @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Sends one beat, idling at random beforehand, and returns once it is taken.
    // Valid stays up after the accepting edge so that a following beat can go
    // out without a gap; whoever stops sending drops it.
    task automatic send_op(logic [2:0] op, logic [31:0] key, logic [3:0] idx,
                           logic [31:0] stamp);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= {1'b0, stamp, idx, key, op};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    // Waits for all answers, then lets the block settle before a register write.
    task automatic write_enable(logic value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        cfg_we <= 1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    // Picks a well-formed operation most of the time, with some noise and
    // illegal codes. Stamps move forward by random amounts, sometimes wrapping.
    task automatic random_op();
        int          pick;
        logic [31:0] key;
        pick = $urandom_range(99);
        key = key_pool[$urandom_range(23)];
        stamp_now += (pick < 5) ? $urandom() : $urandom_range(5000);
        if (pick < 35)
            send_op(czp_pkg::OP_BEGIN, key, 4'($urandom()), stamp_now);
        else if (pick < 70)
            send_op(czp_pkg::OP_END, $urandom(), 4'($urandom_range(15)), stamp_now);
        else if (pick < 82)
            send_op(czp_pkg::OP_READ, $urandom(), 4'($urandom_range(15)), $urandom());
        else if (pick < 90)
            send_op(czp_pkg::OP_STATS, $urandom(), 4'($urandom()), $urandom());
        else if (pick < 92)
            send_op(czp_pkg::OP_CLEAR, $urandom(), 4'($urandom()), $urandom());
        else if (pick < 95)
            send_op(czp_pkg::OP_BEGIN, (pick == 93) ? 32'd0 : $urandom(), 4'($urandom()),
                    $urandom());
        else
            send_op(3'($urandom_range(7, 5)), $urandom(), 4'($urandom()), $urandom());
    endtask

    initial begin
        rst_n = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        in_valid = 0;
        in_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_req = 0;
        items_sent = 0;
        stamp_now = 0;
        for (int i = 0; i < 24; i++) key_pool[i] = $urandom() | 32'h1;
        key_pool[0] = czp_pkg::ALL_ONES;
        key_pool[1] = 32'd1;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Disabled: every operation must be turned away.
        send_op(czp_pkg::OP_BEGIN, 32'd5, 4'd0, 32'd0);
        send_op(czp_pkg::OP_STATS, 32'd0, 4'd0, 32'd0);
        write_enable(1);

        // Directed part: key extremes, zero key, stamp wrap, bad index, inactive end,
        // begin on an active zone, table full, unknown operations and clear.
        send_op(czp_pkg::OP_BEGIN, 32'd0, 4'd0, 32'd0);
        send_op(czp_pkg::OP_BEGIN, czp_pkg::ALL_ONES, 4'd15, 32'hFFFF_FFF0);
        send_op(czp_pkg::OP_END, 32'd0, 4'd0, 32'd16);
        send_op(czp_pkg::OP_END, 32'd0, 4'd0, 32'd16);
        send_op(czp_pkg::OP_BEGIN, 32'd1, 4'd0, 32'd100);
        send_op(czp_pkg::OP_BEGIN, 32'd1, 4'd0, 32'd200);
        send_op(czp_pkg::OP_END, 32'd0, 4'd1, czp_pkg::ALL_ONES);
        send_op(czp_pkg::OP_READ, 32'd0, 4'd1, 32'd0);
        send_op(czp_pkg::OP_READ, 32'd0, 4'd15, 32'd0);
        for (int i = 2; i < 18; i++) send_op(czp_pkg::OP_BEGIN, 32'(i * 977), 4'd0, 32'(i));
        send_op(czp_pkg::OP_STATS, czp_pkg::ALL_ONES, 4'd15, czp_pkg::ALL_ONES);
        send_op(3'd7, czp_pkg::ALL_ONES, 4'd15, czp_pkg::ALL_ONES);
        send_op(3'd5, 32'd0, 4'd0, 32'd0);
        send_op(czp_pkg::OP_CLEAR, 32'd0, 4'd0, 32'd0);
        send_op(czp_pkg::OP_STATS, 32'd0, 4'd0, 32'd0);

        // Random part in idling phases, with a disabled stretch at the start of phase 4.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            if (phase == 4) begin
                write_enable(0);
                for (int i = 0; i < 20; i++) random_op();
                write_enable(1);
            end
            for (int i = 0; i < 200; i++) begin
                if (phase == 0 && i == 50) hold_off_req <= 1;
                if (phase == 0 && i == 51) hold_off_req <= 0;
                random_op();
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        $display("Covered %0d beats: begin, end, zone and global reads, clear and bad codes,",
                 items_sent);
        $display("with the table enabled and disabled under several idle and stall mixes.");
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #60000000;
        $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
